[sv/hpmw_pkg.sv]
package hpmw_pkg;

  // Configuration register widths
  localparam int PERIOD_W = 24;
  localparam int FRAC_W   = 16;
  localparam int TEMP_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Input and result payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Q1.15 full-on value of heat_fraction
  localparam logic [FRAC_W-1:0] FRAC_ONE = 16'd32768;

  // Register reset values
  localparam logic [PERIOD_W-1:0] RST_PERIOD_HEAT    = 24'd8639999;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_MEASURE = 24'd960000;
  localparam logic [PERIOD_W-1:0] RST_COOLDOWN       = 24'd48000;
  localparam logic [FRAC_W-1:0]   RST_HEAT_FRACTION  = 16'd6554;
  localparam logic [TEMP_W-1:0]   RST_TARGET_TEMP    = 16'd0;
  localparam logic                RST_HEATER_ENABLE  = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_HEAT    = 3'd0,
    REG_PERIOD_MEASURE = 3'd1,
    REG_COOLDOWN       = 3'd2,
    REG_HEAT_FRACTION  = 3'd3,
    REG_TARGET_TEMP    = 3'd4,
    REG_HEATER_ENABLE  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_MEASURE = 1'b1
  } op_t;

  typedef enum logic {
    PHASE_HEAT    = 1'b0,
    PHASE_MEASURE = 1'b1
  } phase_t;

  // One result item
  typedef struct packed {
    logic measure_strobe;
    logic load_strobe;
    logic phase;
    logic heater_drive;
  } result_t;

endpackage

[sv/heater_pwm_measure_window.sv]
// Heater PWM with a heater-off measurement window.
//
// Input stream (in_*): one transfer is one item. in_tuser is the operation:
// 0 advances the PWM counter by one tick, 1 delivers a new tip temperature
// in in_tdata that selects the duty for the next heat phase.
// Result stream (out_*): exactly one result per input item, in order, with
// heater drive, phase and the load and measure strobes packed in out_tdata.
// Configuration (cfg_*): register writes by index, always ready; write only
// while the block is idle.
//
// The result is registered: an item transferred at one edge has its result on
// out_* in the cycle after. Throughput is one item per cycle while the receiver
// takes results; the state update, the on-time multiply (span times duty) and
// the drive compare all sit between the input transfer and the result register.
// When the receiver stalls, the result register holds and in_tready drops
// until that result is transferred; a result taken in the same cycle frees
// the slot for the next item.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// counter, phase, on-time and duty, and empties the result register.
module heater_pwm_measure_window #(
  parameter int COUNT_BITS     = 24,
  parameter int DUTY_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [hpmw_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] tip_temperature
  input  logic                                 in_tuser,   // [0] operation
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] heater_drive, [1] phase, [2] load_strobe, [3] measure_strobe, [7:4] zero
  output logic [hpmw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hpmw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpmw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DUTY_W  = DUTY_FRAC_BITS + 1;
  localparam int PROD_W  = hpmw_pkg::PERIOD_W + DUTY_W;
  // Q1.15 to DUTY_FRAC_BITS conversion shifts
  localparam int FRAC_SHL = (DUTY_FRAC_BITS >= 15) ? DUTY_FRAC_BITS - 15 : 0;
  localparam int FRAC_SHR = (DUTY_FRAC_BITS >= 15) ? 0 : 15 - DUTY_FRAC_BITS;

  // Configuration registers
  logic [hpmw_pkg::PERIOD_W-1:0] period_heat_r;
  logic [hpmw_pkg::PERIOD_W-1:0] period_measure_r;
  logic [hpmw_pkg::PERIOD_W-1:0] cooldown_r;
  logic [hpmw_pkg::FRAC_W-1:0]   heat_fraction_r;
  logic [hpmw_pkg::TEMP_W-1:0]   target_temp_r;
  logic                          heater_enable_r;

  // PWM state
  hpmw_pkg::phase_t              phase_r,  phase_nxt;
  logic [COUNT_BITS-1:0]         tick_r,   tick_nxt;
  logic [COUNT_BITS-1:0]         on_r,     on_nxt;
  logic [DUTY_W-1:0]             duty_r,   duty_nxt;

  // Result register
  logic                          out_valid_r;
  hpmw_pkg::result_t             result_r, result_nxt;

  logic                          in_fire;
  logic                          out_fire;

  // Datapath
  logic [COUNT_BITS-1:0]         period_heat_c;
  logic [COUNT_BITS-1:0]         period_measure_c;
  logic [COUNT_BITS-1:0]         period_c;
  logic [31:0]                   period_heat_ext;
  logic [31:0]                   period_measure_ext;
  logic [31:0]                   cool_ext;
  logic [hpmw_pkg::PERIOD_W-1:0] span_c;
  logic [PROD_W-1:0]             prod_c;
  logic [63:0]                   prod_sh;
  logic [COUNT_BITS-1:0]         on_calc;
  logic [hpmw_pkg::FRAC_W-1:0]   frac_clamped;
  logic [31:0]                   frac_shifted;
  logic                          phase_end;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  // Accept while the result slot is empty or being drained this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hpmw_pkg::OUT_TDATA_W-4){1'b0}}, result_r};

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_heat_r    <= hpmw_pkg::RST_PERIOD_HEAT;
      period_measure_r <= hpmw_pkg::RST_PERIOD_MEASURE;
      cooldown_r       <= hpmw_pkg::RST_COOLDOWN;
      heat_fraction_r  <= hpmw_pkg::RST_HEAT_FRACTION;
      target_temp_r    <= hpmw_pkg::RST_TARGET_TEMP;
      heater_enable_r  <= hpmw_pkg::RST_HEATER_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hpmw_pkg::REG_PERIOD_HEAT:    period_heat_r    <= cfg_data;
        hpmw_pkg::REG_PERIOD_MEASURE: period_measure_r <= cfg_data;
        hpmw_pkg::REG_COOLDOWN:       cooldown_r       <= cfg_data;
        hpmw_pkg::REG_HEAT_FRACTION:  heat_fraction_r  <= cfg_data[hpmw_pkg::FRAC_W-1:0];
        hpmw_pkg::REG_TARGET_TEMP:    target_temp_r    <= cfg_data[hpmw_pkg::TEMP_W-1:0];
        hpmw_pkg::REG_HEATER_ENABLE:  heater_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Periods fit to the counter width (truncate or zero-extend)
  assign period_heat_ext    = {{(32-hpmw_pkg::PERIOD_W){1'b0}}, period_heat_r};
  assign period_measure_ext = {{(32-hpmw_pkg::PERIOD_W){1'b0}}, period_measure_r};
  assign period_heat_c      = period_heat_ext[COUNT_BITS-1:0];
  assign period_measure_c   = period_measure_ext[COUNT_BITS-1:0];
  assign period_c = (phase_r == hpmw_pkg::PHASE_MEASURE) ? period_measure_c : period_heat_c;

  // On-time for the next heat phase: max(0, heat - cooldown) * duty
  always_comb begin
    logic [31:0] heat_m;
    logic [31:0] diff;
    heat_m   = {{(32-COUNT_BITS){1'b0}}, period_heat_c};
    cool_ext = {{(32-hpmw_pkg::PERIOD_W){1'b0}}, cooldown_r};
    diff     = heat_m - cool_ext;
    span_c   = (heat_m > cool_ext) ? diff[hpmw_pkg::PERIOD_W-1:0] : '0;
  end

  assign prod_c  = PROD_W'(span_c) * PROD_W'(duty_r);
  assign prod_sh = 64'(prod_c) >> DUTY_FRAC_BITS;
  assign on_calc = prod_sh[COUNT_BITS-1:0];

  // heat_fraction clamped to full on and moved to the duty scale
  assign frac_clamped = (heat_fraction_r > hpmw_pkg::FRAC_ONE) ? hpmw_pkg::FRAC_ONE
                                                               : heat_fraction_r;
  assign frac_shifted = (32'(frac_clamped) << FRAC_SHL) >> FRAC_SHR;

  assign phase_end = (tick_r >= period_c);

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    on_nxt     = on_r;
    duty_nxt   = duty_r;
    result_nxt = '0;
    if (in_tuser == hpmw_pkg::OP_TICK) begin
      if (phase_end) begin
        tick_nxt = '0;
        if (phase_r == hpmw_pkg::PHASE_HEAT) begin
          // enter the measurement window with the drive off
          result_nxt.load_strobe = (on_r != '0);
          phase_nxt              = hpmw_pkg::PHASE_MEASURE;
        end else begin
          // request a sample and start the next heat phase
          result_nxt.measure_strobe = 1'b1;
          phase_nxt                 = hpmw_pkg::PHASE_HEAT;
          on_nxt                    = on_calc;
        end
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end else begin
      if (heater_enable_r && (target_temp_r > in_tdata)) begin
        duty_nxt = frac_shifted[DUTY_W-1:0];
      end else begin
        duty_nxt = '0;
      end
    end
    result_nxt.phase        = phase_nxt;
    result_nxt.heater_drive = (phase_nxt == hpmw_pkg::PHASE_HEAT) && (tick_nxt < on_nxt);
  end

  // Advance state on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hpmw_pkg::PHASE_HEAT;
      tick_r  <= '0;
      on_r    <= '0;
      duty_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      on_r    <= on_nxt;
      duty_r  <= duty_nxt;
    end
  end

  // Result slot: load on transfer in, clear when taken and not refilled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  // An accepted item always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  // Drive is only on during the heat phase
  a_drive_in_heat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.heater_drive |-> result_r.phase == hpmw_pkg::PHASE_HEAT)
    else $error("heater drive on outside heat phase");

  // Load strobe marks entry to measurement, measure strobe marks entry to heat
  a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.load_strobe |-> result_r.phase == hpmw_pkg::PHASE_MEASURE)
    else $error("load strobe outside measurement entry");

  a_measure_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.measure_strobe |->
      result_r.phase == hpmw_pkg::PHASE_HEAT && tick_r == '0)
    else $error("measure strobe without heat phase restart");

  // A measurement item leaves counter and phase untouched
  a_measure_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == hpmw_pkg::OP_MEASURE |=> $stable(tick_r) && $stable(phase_r))
    else $error("measurement item moved the counter");

endmodule

[sim/tb.sv]
module tb;

  // Duty carries 15 fraction bits at the default build, so a Q1.15 fraction
  // maps onto it unchanged.
  localparam int DUTY_FRAC = 15;
  localparam logic [hpmw_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int ROUNDS      = 14;
  localparam int ROUND_ITEMS = 100;
  localparam int MAX_REPORTS = 10;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [hpmw_pkg::IN_TDATA_W-1:0] in_tdata   = '0;    // [15:0] tip_temperature
  logic                            in_tuser   = 1'b0;  // [0] operation
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [0] heater_drive, [1] phase, [2] load_strobe, [3] measure_strobe, [7:4] zero
  logic [hpmw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [hpmw_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [hpmw_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Set during the stretch where neither side may idle.
  bit quiet = 1'b0;

  // Tracks the PWM timer and duty, and queues the drive/phase/strobe result
  // that each accepted item must produce.
  class pwm_window_model;
    logic [hpmw_pkg::PERIOD_W-1:0] heat_period;
    logic [hpmw_pkg::PERIOD_W-1:0] measure_period;
    logic [hpmw_pkg::PERIOD_W-1:0] cooldown;
    logic [hpmw_pkg::FRAC_W-1:0]   fraction;
    logic [hpmw_pkg::TEMP_W-1:0]   target;
    logic                          enable;
    hpmw_pkg::phase_t              cur_phase;
    logic [hpmw_pkg::PERIOD_W-1:0] count;
    logic [hpmw_pkg::PERIOD_W-1:0] on_ticks;
    logic [hpmw_pkg::FRAC_W-1:0]   duty;
    hpmw_pkg::result_t             results_due[$];
    int                            mismatches;

    function new();
      heat_period    = hpmw_pkg::RST_PERIOD_HEAT;
      measure_period = hpmw_pkg::RST_PERIOD_MEASURE;
      cooldown       = hpmw_pkg::RST_COOLDOWN;
      fraction       = hpmw_pkg::RST_HEAT_FRACTION;
      target         = hpmw_pkg::RST_TARGET_TEMP;
      enable         = hpmw_pkg::RST_HEATER_ENABLE;
      cur_phase      = hpmw_pkg::PHASE_HEAT;
      count          = '0;
      on_ticks       = '0;
      duty           = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [hpmw_pkg::CFG_IDX_W-1:0]  idx,
                            logic [hpmw_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        hpmw_pkg::REG_PERIOD_HEAT:    heat_period    = value;
        hpmw_pkg::REG_PERIOD_MEASURE: measure_period = value;
        hpmw_pkg::REG_COOLDOWN:       cooldown       = value;
        hpmw_pkg::REG_HEAT_FRACTION:  fraction       = value[hpmw_pkg::FRAC_W-1:0];
        hpmw_pkg::REG_TARGET_TEMP:    target         = value[hpmw_pkg::TEMP_W-1:0];
        hpmw_pkg::REG_HEATER_ENABLE:  enable         = value[0];
        default: ;
      endcase
    endfunction

    // On-time of the next heat phase: (heat period - cooldown) scaled by duty.
    function logic [hpmw_pkg::PERIOD_W-1:0] next_on_ticks();
      logic [hpmw_pkg::PERIOD_W-1:0]                  span;
      logic [hpmw_pkg::PERIOD_W+hpmw_pkg::FRAC_W-1:0] product;
      span    = (heat_period > cooldown) ? heat_period - cooldown : '0;
      product = span * duty;
      return hpmw_pkg::PERIOD_W'(product >> DUTY_FRAC);
    endfunction

    function void take_item(hpmw_pkg::op_t op, logic [hpmw_pkg::TEMP_W-1:0] tip);
      logic [hpmw_pkg::PERIOD_W-1:0] last_count;
      hpmw_pkg::result_t             res;
      res = '0;
      if (op == hpmw_pkg::OP_TICK) begin
        last_count = (cur_phase == hpmw_pkg::PHASE_MEASURE) ? measure_period : heat_period;
        if (count >= last_count) begin
          count = '0;
          if (cur_phase == hpmw_pkg::PHASE_HEAT) begin
            res.load_strobe = (on_ticks != '0);
            cur_phase = hpmw_pkg::PHASE_MEASURE;
          end else begin
            res.measure_strobe = 1'b1;
            cur_phase = hpmw_pkg::PHASE_HEAT;
            on_ticks = next_on_ticks();
          end
        end else begin
          count = count + 1'b1;
        end
      end else begin
        // Heat only when enabled and the tip is below target; clamp to full on.
        if (enable && target > tip) begin
          duty = (fraction > hpmw_pkg::FRAC_ONE) ? hpmw_pkg::FRAC_ONE : fraction;
        end else begin
          duty = '0;
        end
      end
      res.heater_drive = (cur_phase == hpmw_pkg::PHASE_HEAT) && (count < on_ticks);
      res.phase        = cur_phase;
      results_due.push_back(res);
    endfunction

    function void check_result(logic [hpmw_pkg::OUT_TDATA_W-1:0] tdata);
      hpmw_pkg::result_t want;
      hpmw_pkg::result_t got;
      got = tdata[3:0];
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result transfer, out_tdata=%h", $time, tdata);
        end
        return;
      end
      want = results_due.pop_front();
      if (got.heater_drive !== want.heater_drive || got.phase !== want.phase ||
          got.load_strobe !== want.load_strobe ||
          got.measure_strobe !== want.measure_strobe ||
          tdata[hpmw_pkg::OUT_TDATA_W-1:4] !== '0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: exp/act drive %b/%b phase %b/%b load %b/%b meas %b/%b pad 0/%h",
                   $time, want.heater_drive, got.heater_drive, want.phase, got.phase,
                   want.load_strobe, got.load_strobe, want.measure_strobe, got.measure_strobe,
                   tdata[hpmw_pkg::OUT_TDATA_W-1:4]);
        end
      end
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction
  endclass

  pwm_window_model model = new();

  heater_pwm_measure_window dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, with 9 percent probability, never while quiet.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99, 0) >= 9);
  end

  // Check result transfers first, then note the input transfer of this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) model.check_result(out_tdata);
      if (in_tvalid && in_tready) model.take_item(hpmw_pkg::op_t'(in_tuser), in_tdata);
    end
  end

  // Offer one item, idling first at random; return at the edge of its transfer.
  task automatic send_item(hpmw_pkg::op_t op, logic [hpmw_pkg::TEMP_W-1:0] tip);
    if (!quiet && $urandom_range(99, 0) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tip;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Timer ticks carry random, ignored temperature bits.
  task automatic tick(int n);
    repeat (n) send_item(hpmw_pkg::OP_TICK, hpmw_pkg::TEMP_W'($urandom));
  endtask

  // Drop valid, wait for every result, then let the pipe drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; hold valid until the transfer, then drop it.
  task automatic write_reg(logic [hpmw_pkg::CFG_IDX_W-1:0]  idx,
                           logic [hpmw_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Tick one at a time until the block reaches the wanted phase.
  task automatic run_to(hpmw_pkg::phase_t want);
    while (model.cur_phase != want) begin
      tick(1);
      settle();
    end
  endtask

  initial begin
    logic [hpmw_pkg::TEMP_W-1:0] tgt;
    int                          near;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: long heat period, zero on-time, heating disabled.
    tick(2);
    send_item(hpmw_pkg::OP_MEASURE, 16'h0000);
    send_item(hpmw_pkg::OP_MEASURE, 16'hFFFF);
    settle();

    // Short periods at full duty: first heat phase ends with no load strobe,
    // then a heat phase with on-time 3 of 4 ticks and a load strobe.
    write_reg(hpmw_pkg::REG_PERIOD_HEAT, 24'd3);
    write_reg(hpmw_pkg::REG_PERIOD_MEASURE, 24'd2);
    write_reg(hpmw_pkg::REG_COOLDOWN, 24'd0);
    write_reg(hpmw_pkg::REG_HEAT_FRACTION, 24'(hpmw_pkg::FRAC_ONE));
    write_reg(hpmw_pkg::REG_TARGET_TEMP, 24'h00FFFF);
    write_reg(hpmw_pkg::REG_HEATER_ENABLE, 24'd1);
    send_item(hpmw_pkg::OP_MEASURE, 16'h0000);
    tick(11);
    // Tip equal to target: no heating.
    send_item(hpmw_pkg::OP_MEASURE, 16'hFFFF);
    tick(5);
    settle();

    // Fraction above full clamps; cooldown past the heat period gives zero on-time.
    write_reg(hpmw_pkg::REG_HEAT_FRACTION, 24'hFFFFFF);
    write_reg(hpmw_pkg::REG_COOLDOWN, 24'd5);
    write_reg(CFG_IDX_UNUSED, 24'hFFFFFF);
    send_item(hpmw_pkg::OP_MEASURE, 16'd100);
    tick(8);
    settle();
    write_reg(hpmw_pkg::REG_COOLDOWN, 24'd1);
    tick(8);
    settle();

    // Zero periods: each phase lasts a single tick.
    write_reg(hpmw_pkg::REG_PERIOD_HEAT, 24'd0);
    write_reg(hpmw_pkg::REG_PERIOD_MEASURE, 24'd0);
    tick(3);
    settle();

    // Widest heat period, no cooldown, full duty: drive stays on, then cut
    // the period short to end the phase with a load strobe.
    write_reg(hpmw_pkg::REG_PERIOD_HEAT, 24'd2);
    write_reg(hpmw_pkg::REG_PERIOD_MEASURE, 24'd1);
    run_to(hpmw_pkg::PHASE_MEASURE);
    write_reg(hpmw_pkg::REG_PERIOD_HEAT, 24'hFFFFFF);
    write_reg(hpmw_pkg::REG_COOLDOWN, 24'd0);
    send_item(hpmw_pkg::OP_MEASURE, 16'h0000);
    settle();
    run_to(hpmw_pkg::PHASE_HEAT);
    tick(3);
    settle();
    write_reg(hpmw_pkg::REG_PERIOD_HEAT, 24'd2);
    run_to(hpmw_pkg::PHASE_MEASURE);
    // Widest measurement period, then back to short.
    write_reg(hpmw_pkg::REG_PERIOD_MEASURE, 24'hFFFFFF);
    tick(3);
    settle();
    write_reg(hpmw_pkg::REG_PERIOD_MEASURE, 24'd1);
    tick(3);
    settle();

    // Random rounds: new settings each round, mostly ticks with measurements
    // near the target so the duty flips both ways.
    for (int r = 0; r < ROUNDS; r++) begin
      quiet <= (r == 6 || r == 7);
      if (r == 5) begin
        write_reg(hpmw_pkg::REG_PERIOD_HEAT, hpmw_pkg::CFG_DATA_W'($urandom));
        write_reg(hpmw_pkg::REG_PERIOD_MEASURE, hpmw_pkg::CFG_DATA_W'($urandom));
        write_reg(hpmw_pkg::REG_COOLDOWN, hpmw_pkg::CFG_DATA_W'($urandom));
      end else begin
        write_reg(hpmw_pkg::REG_PERIOD_HEAT, hpmw_pkg::CFG_DATA_W'($urandom_range(40, 0)));
        write_reg(hpmw_pkg::REG_PERIOD_MEASURE,
                  hpmw_pkg::CFG_DATA_W'($urandom_range(12, 0)));
        write_reg(hpmw_pkg::REG_COOLDOWN, hpmw_pkg::CFG_DATA_W'($urandom_range(45, 0)));
      end
      case ($urandom_range(3, 0))
        0: write_reg(hpmw_pkg::REG_HEAT_FRACTION, hpmw_pkg::CFG_DATA_W'(hpmw_pkg::FRAC_ONE));
        1: write_reg(hpmw_pkg::REG_HEAT_FRACTION,
                     hpmw_pkg::CFG_DATA_W'($urandom_range(32768, 0)));
        2: write_reg(hpmw_pkg::REG_HEAT_FRACTION, hpmw_pkg::CFG_DATA_W'($urandom));
        default: write_reg(hpmw_pkg::REG_HEAT_FRACTION, '0);
      endcase
      tgt = hpmw_pkg::TEMP_W'($urandom);
      write_reg(hpmw_pkg::REG_TARGET_TEMP, {8'($urandom), tgt});
      write_reg(hpmw_pkg::REG_HEATER_ENABLE, {23'($urandom), 1'($urandom_range(3, 0) != 0)});
      if ($urandom_range(3, 0) == 0) write_reg(CFG_IDX_UNUSED, hpmw_pkg::CFG_DATA_W'($urandom));

      for (int i = 0; i < ROUND_ITEMS; i++) begin
        if ($urandom_range(99, 0) < 15) begin
          if ($urandom_range(9, 0) < 7) begin
            near = int'(tgt) + int'($urandom_range(8, 0)) - 4;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            send_item(hpmw_pkg::OP_MEASURE, hpmw_pkg::TEMP_W'(near));
          end else begin
            send_item(hpmw_pkg::OP_MEASURE, hpmw_pkg::TEMP_W'($urandom));
          end
        end else begin
          tick(1);
        end
      end
      settle();
    end

    repeat (5) @(posedge clk);
    if (model.mismatches == 0 && model.outstanding() == 0) begin
      $display("heater_pwm_measure_window test passed");
    end else begin
      $display("heater_pwm_measure_window test failed");
    end
    $finish;
  end

  // Bound the run far beyond the slowest correct one.
  initial begin
    #2000000;
    $display("heater_pwm_measure_window test failed");
    $finish;
  end

endmodule

[filelist.f]
sv/hpmw_pkg.sv
sv/heater_pwm_measure_window.sv
sim/tb.sv
